@@ sv/srtc_pkg.sv @@
`timescale 1ns / 1ps

package srtc_pkg;

  localparam int NumOutBytes = 7;
  localparam logic [2:0] LastOutByte = 3'd6;

  localparam logic [2:0] CmdStatus = 3'd0;
  localparam logic [2:0] CmdDateTime = 3'd2;

  typedef enum logic [1:0] {
    FAULT_NONE       = 2'd0,
    FAULT_UNKNOWN    = 2'd1,
    FAULT_PARAM      = 2'd2,
    FAULT_READ_CLKLO = 2'd3
  } fault_t;

  typedef struct packed {
    logic [15:0] port_value;
    fault_t      fault_code;
  } result_t;

  // Binary to two BCD digits, kept to 8 bits; the tens digit comes from a
  // reciprocal multiply that is exact for every 7-bit value.
  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  ones;
    prod = {8'b0, v} * 15'd205;
    tens = prod[14:11];
    ones = v - 7'({3'b0, tens} * 7'd10);
    return {tens, ones[3:0]};
  endfunction

endpackage

@@ sv/srtc_out_skid.sv @@
`timescale 1ns / 1ps

module srtc_out_skid import srtc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  result_t in_data,
  output logic    in_stall,
  output logic    out_valid,
  output result_t out_data,
  input  logic    out_stall
);

  logic    main_valid;
  logic    skid_valid;
  result_t main_data;
  result_t skid_data;
  logic    accept;
  logic    drain;

  assign accept = in_valid && !skid_valid;
  assign drain = main_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!main_valid || drain) begin
        if (skid_valid) begin
          main_data  <= skid_data;
          main_valid <= 1'b1;
          skid_valid <= 1'b0;
        end else if (accept) begin
          main_data  <= in_data;
          main_valid <= 1'b1;
        end else begin
          main_valid <= 1'b0;
        end
      end else if (accept) begin
        // The result register is held by the consumer, so park this one.
        skid_data  <= in_data;
        skid_valid <= 1'b1;
      end
    end
  end

  assign in_stall = skid_valid;
  assign out_valid = main_valid;
  assign out_data = main_data;

endmodule

@@ sv/serial_rtc_command_interface_unit.sv @@
`timescale 1ns / 1ps
// Serial RTC port register: one port write is taken per cycle when not stalled.
// The result is registered in the output stage; it is parked in a skid entry while the output is stalled.
// Throughput is one write per cycle while not stalled; a two-entry output stage absorbs stalls.
// Reset (rst, synchronous) clears the port latch, shift state, output buffer
// and status1; no clearing pass is needed.
module serial_rtc_command_interface_unit import srtc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] write_value,
  input  logic        byte_write,
  input  logic [6:0]  now_year,
  input  logic [3:0]  now_month,
  input  logic [4:0]  now_day,
  input  logic [2:0]  now_weekday,
  input  logic [4:0]  now_hour,
  input  logic [5:0]  now_minute,
  input  logic [5:0]  now_second,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] port_value,
  output logic [1:0]  fault_code
);

  logic [7:0]  status1;
  logic [15:0] port_latch;
  logic [7:0]  shift_in;
  logic [2:0]  in_bit_count;
  logic        command_seen;
  logic [7:0]  out_buffer [NumOutBytes];
  logic [2:0]  out_bit_count;
  logic [2:0]  out_byte_index;

  logic [15:0] port_latch_next;
  logic [7:0]  shift_in_next;
  logic [2:0]  in_bit_count_next;
  logic        command_seen_next;
  logic [7:0]  out_buffer_next [NumOutBytes];
  logic [2:0]  out_bit_count_next;
  logic [2:0]  out_byte_index_next;

  logic        accept;
  logic [15:0] value;
  logic        sdata;
  logic        sclk;
  logic        sel;
  logic        wr;
  logic [7:0]  shifted;
  logic [2:0]  cmd;
  logic [2:0]  rd_index;
  logic        out_bit;
  logic        bit0;
  logic [4:0]  hour12;
  logic [7:0]  hour_bcd;
  fault_t      fault;
  result_t     result;
  result_t     out_result;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {24'b0, status1} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      status1 <= 8'h00;
    end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
      status1 <= pwdata[7:0];
    end
  end

  assign accept = in_valid && !in_stall;

  assign value = byte_write ? {port_latch[15:8], write_value[7:0]} : write_value;
  assign sdata = value[0];
  assign sclk = value[1];
  assign sel = value[2];
  assign wr = value[4];

  assign shifted = shift_in | ({7'b0, sdata} << in_bit_count);
  assign cmd = shifted[6:4];
  assign rd_index = (out_byte_index > LastOutByte) ? LastOutByte : out_byte_index;

  always_comb begin
    if (now_hour >= 5'd24) begin
      hour12 = now_hour - 5'd24;
    end else if (now_hour >= 5'd12) begin
      hour12 = now_hour - 5'd12;
    end else begin
      hour12 = now_hour;
    end
    hour_bcd = status1[1] ? to_bcd({2'b0, now_hour}) : to_bcd({2'b0, hour12});
    if (now_hour >= 5'd12) begin
      hour_bcd = hour_bcd | 8'h40;
    end
  end

  always_comb begin
    shift_in_next       = shift_in;
    in_bit_count_next   = in_bit_count;
    command_seen_next   = command_seen;
    out_buffer_next     = out_buffer;
    out_bit_count_next  = out_bit_count;
    out_byte_index_next = out_byte_index;
    fault               = FAULT_NONE;
    out_bit             = out_buffer[rd_index][out_bit_count];
    bit0                = port_latch[0];
    if (sel) begin
      if (!port_latch[2]) begin
        // Select rising restarts a transfer.
        shift_in_next       = 8'h00;
        in_bit_count_next   = 3'd0;
        command_seen_next   = 1'b0;
        out_bit_count_next  = 3'd0;
        out_byte_index_next = 3'd0;
      end else if (!sclk) begin
        if (wr) begin
          in_bit_count_next = in_bit_count + 3'd1;
          shift_in_next = shifted;
          if (in_bit_count_next == 3'd0) begin
            shift_in_next = 8'h00;
            if (command_seen) begin
              fault = FAULT_PARAM;
            end else begin
              command_seen_next = 1'b1;
              if (shifted[7]) begin
                if (cmd == CmdStatus) begin
                  out_buffer_next[0] = status1;
                end else if (cmd == CmdDateTime) begin
                  out_buffer_next[0] = to_bcd(now_year);
                  out_buffer_next[1] = to_bcd({3'b0, now_month});
                  out_buffer_next[2] = to_bcd({2'b0, now_day});
                  out_buffer_next[3] = to_bcd({4'b0, now_weekday});
                  out_buffer_next[4] = hour_bcd;
                  out_buffer_next[5] = to_bcd({1'b0, now_minute});
                  out_buffer_next[6] = to_bcd({1'b0, now_second});
                end else begin
                  fault = FAULT_UNKNOWN;
                end
              end
            end
          end
        end else begin
          fault = FAULT_READ_CLKLO;
        end
      end else begin
        bit0 = out_bit;
        out_bit_count_next = out_bit_count + 3'd1;
        if ((out_bit_count_next == 3'd0) && (out_byte_index < LastOutByte)) begin
          out_byte_index_next = out_byte_index + 3'd1;
        end
      end
    end
    port_latch_next = wr ? value : {8'h00, value[7:1], bit0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      port_latch     <= 16'h0000;
      shift_in       <= 8'h00;
      in_bit_count   <= 3'd0;
      command_seen   <= 1'b0;
      out_buffer     <= '{default: 8'h00};
      out_bit_count  <= 3'd0;
      out_byte_index <= 3'd0;
    end else if (accept) begin
      port_latch     <= port_latch_next;
      shift_in       <= shift_in_next;
      in_bit_count   <= in_bit_count_next;
      command_seen   <= command_seen_next;
      out_buffer     <= out_buffer_next;
      out_bit_count  <= out_bit_count_next;
      out_byte_index <= out_byte_index_next;
    end
  end

  assign result.port_value = port_latch_next;
  assign result.fault_code = fault;

  srtc_out_skid u_out_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_data   (result),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_data  (out_result),
    .out_stall (out_stall)
  );

  assign port_value = out_result.port_value;
  assign fault_code = out_result.fault_code;

  // The output byte pointer never leaves the buffer.
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    out_byte_index <= LastOutByte)
    else $error("output byte index past last byte");

  // A read-direction fault never comes with a written direction bit.
  a_fault_dir: assert property (@(posedge clk) disable iff (rst)
    out_valid && (fault_code == FAULT_READ_CLKLO) |->
      (port_value[4] == 1'b0) && (port_value[15:8] == 8'h00))
    else $error("clock-low fault with direction set in port value");

  // Select rising restarts the input shift count and clears the command flag.
  a_sel_restart: assert property (@(posedge clk) disable iff (rst)
    accept && sel && !port_latch[2] |=> (in_bit_count == 3'd0) && !command_seen)
    else $error("select rising did not restart the shift state");

  // Once a result is parked, the upstream side is held off.
  a_stall_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no result waiting");

endmodule
